// ===== rtl/mlfq_pkg.sv =====
// Shared types and constants for the multilevel feedback queue scheduler.
// No dependencies; every other file imports this package.
package mlfq_pkg;

  // Default sizes
  localparam int unsigned DefNumLevels = 5;
  localparam int unsigned DefNumSlots  = 64;

  // Fixed field widths
  localparam int unsigned CmdW    = 3;
  localparam int unsigned SlotIdW = 6;
  localparam int unsigned TickW   = 16;
  localparam int unsigned LvlW    = 3;
  localparam int unsigned StW     = 2;
  localparam int unsigned InDataW  = 48;
  localparam int unsigned OutDataW = 16;

  // Register reset value
  localparam logic [TickW-1:0] AgeLimitRst = 16'd30;

  // Commands
  localparam logic [CmdW-1:0] CmdReady = 3'd0;
  localparam logic [CmdW-1:0] CmdBlock = 3'd1;
  localparam logic [CmdW-1:0] CmdAge   = 3'd2;
  localparam logic [CmdW-1:0] CmdTick  = 3'd3;
  localparam logic [CmdW-1:0] CmdPick  = 3'd4;

  // Status codes
  localparam logic [StW-1:0] StOk       = 2'd0;
  localparam logic [StW-1:0] StFull     = 2'd1;
  localparam logic [StW-1:0] StNotFound = 2'd2;

endpackage

// ===== rtl/mlfq_entry_mem.sv =====
// Queue entry storage: one synchronous memory holding all level queues.
// Depends on mlfq_pkg for the slot id width.
module mlfq_entry_mem
  import mlfq_pkg::*;
#(
  parameter int unsigned DEPTH = DefNumLevels * DefNumSlots,
  localparam int unsigned AW = $clog2(DEPTH)
) (
  input  logic               clk_i,
  input  logic               we_i,
  input  logic [AW-1:0]      waddr_i,
  input  logic [SlotIdW-1:0] wdata_i,
  input  logic               re_i,
  input  logic [AW-1:0]      raddr_i,
  output logic [SlotIdW-1:0] rdata_o
);

  logic [SlotIdW-1:0] mem [DEPTH];
  logic [SlotIdW-1:0] rdata_q;

  // Write port and registered read port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== rtl/mlfq_level_mem.sv =====
// Per-slot level storage: synchronous memory with reset-cleared valid bits,
// an entry never written reads as level zero. Depends on mlfq_pkg.
module mlfq_level_mem
  import mlfq_pkg::*;
#(
  parameter int unsigned NUM_SLOTS = DefNumSlots,
  localparam int unsigned SW = $clog2(NUM_SLOTS)
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            we_i,
  input  logic [SW-1:0]   waddr_i,
  input  logic [LvlW-1:0] wdata_i,
  input  logic            re_i,
  input  logic [SW-1:0]   raddr_i,
  output logic [LvlW-1:0] rdata_o
);

  logic [LvlW-1:0]      mem [NUM_SLOTS];
  logic [LvlW-1:0]      rdata_q;
  logic [NUM_SLOTS-1:0] vld_q;
  logic                 rd_vld_q;

  // Storage and registered read data
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  // Track written entries
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q    <= '0;
      rd_vld_q <= 1'b0;
    end else begin
      if (we_i) begin
        vld_q[waddr_i] <= 1'b1;
      end
      if (re_i) begin
        rd_vld_q <= vld_q[raddr_i];
      end
    end
  end

  assign rdata_o = rd_vld_q ? rdata_q : '0;

endmodule

// ===== rtl/mlfq_scheduler_queues.sv =====
// Multilevel feedback queue scheduler: top level with the command sequencer.
// Depends on mlfq_pkg, mlfq_entry_mem and mlfq_level_mem.
//
// One command is taken at a time. Every command first reads the slot's level,
// then ready pushes an unqueued slot and pick reads the head of the highest
// nonempty queue. Block, age and tick walk the level queue through the
// single-port-per-side entry memory: the search reads and checks each entry
// visited, and the removal reads and rewrites each entry moved forward. The
// result sits in an output register, so the next command is taken while the
// previous result waits for its transfer. There is no clearing pass after
// reset; age_limit resets to 30.
module mlfq_scheduler_queues
  import mlfq_pkg::*;
#(
  parameter int unsigned NUM_LEVELS = DefNumLevels,
  parameter int unsigned NUM_SLOTS  = DefNumSlots
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [TickW-1:0]    cfg_wdata_i,     // age_limit
  input  logic                s_axis_tvalid,
  output logic                s_axis_tready,
  // cmd[2:0], slot_id[8:3], wait_ticks[24:9], run_ticks[40:25], zero[47:41]
  input  logic [InDataW-1:0]  s_axis_tdata,
  output logic                m_axis_tvalid,
  input  logic                m_axis_tready,
  // chosen_valid[0], chosen_slot[6:1], preempt[7], status[9:8],
  // slot_level[12:10], zero[15:13]
  output logic [OutDataW-1:0] m_axis_tdata
);

  localparam int unsigned SW    = $clog2(NUM_SLOTS);
  localparam int unsigned LIW   = $clog2(NUM_LEVELS);
  localparam int unsigned CW    = $clog2(NUM_SLOTS + 1);
  localparam int unsigned DEPTH = NUM_LEVELS * NUM_SLOTS;
  localparam int unsigned AW    = $clog2(DEPTH);

  localparam logic [3:0] ST_IDLE  = 4'd0;
  localparam logic [3:0] ST_SLOT  = 4'd1;
  localparam logic [3:0] ST_PICK  = 4'd2;
  localparam logic [3:0] ST_SRD   = 4'd3;
  localparam logic [3:0] ST_SCHK  = 4'd4;
  localparam logic [3:0] ST_RMRD  = 4'd5;
  localparam logic [3:0] ST_RMCLR = 4'd6;
  localparam logic [3:0] ST_SHRD  = 4'd7;
  localparam logic [3:0] ST_SHWR  = 4'd8;
  localparam logic [3:0] ST_PUSH  = 4'd9;
  localparam logic [3:0] ST_FIN   = 4'd10;
  localparam logic [3:0] ST_OUT   = 4'd11;

  function automatic logic [AW-1:0] ent_addr(logic [LIW-1:0] lvl, logic [CW-1:0] idx);
    ent_addr = AW'(lvl) * AW'(NUM_SLOTS) + AW'(idx);
  endfunction

  logic [3:0]         state_q, state_d;
  logic [CmdW-1:0]    cmd_q, cmd_d;
  logic [SlotIdW-1:0] sid_q, sid_d;
  logic [TickW-1:0]   wt_q, wt_d, rt_q, rt_d;
  logic               ok_q, ok_d;
  logic [LIW-1:0]     l_q, l_d, nl_q, nl_d, tgt_q, tgt_d;
  logic               fire_q, fire_d;
  logic [CW-1:0]      idx_q, idx_d;
  logic [CW-1:0]      cnt_q [NUM_LEVELS];
  logic [CW-1:0]      cnt_d [NUM_LEVELS];
  logic [NUM_SLOTS-1:0] queued_q, queued_d;
  logic [TickW-1:0]   age_limit_q;

  logic               r_cv_q, r_cv_d, r_pre_q, r_pre_d;
  logic [SlotIdW-1:0] r_cs_q, r_cs_d;
  logic [StW-1:0]     r_st_q, r_st_d;
  logic [LvlW-1:0]    r_lv_q, r_lv_d;

  logic                out_valid_q, out_valid_d;
  logic [OutDataW-1:0] out_data_q, out_data_d;

  logic               ent_we, ent_re;
  logic [AW-1:0]      ent_waddr, ent_raddr;
  logic [SlotIdW-1:0] ent_wdata, ent_rdata;
  logic               lvl_we, lvl_re;
  logic [SW-1:0]      lvl_waddr, lvl_raddr;
  logic [LvlW-1:0]    lvl_wdata, lvl_rdata;

  logic [SW-1:0]      sid_idx;
  logic [LIW-1:0]     l_eff, nl_eff, fl;
  logic               found;
  logic [LIW-1:0]     found_lvl;
  logic               hi_busy;

  assign sid_idx = SW'(sid_q);

  mlfq_entry_mem #(.DEPTH(DEPTH)) u_entry_mem (
    .clk_i   (clk_i),
    .we_i    (ent_we),
    .waddr_i (ent_waddr),
    .wdata_i (ent_wdata),
    .re_i    (ent_re),
    .raddr_i (ent_raddr),
    .rdata_o (ent_rdata)
  );

  mlfq_level_mem #(.NUM_SLOTS(NUM_SLOTS)) u_level_mem (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .we_i    (lvl_we),
    .waddr_i (lvl_waddr),
    .wdata_i (lvl_wdata),
    .re_i    (lvl_re),
    .raddr_i (lvl_raddr),
    .rdata_o (lvl_rdata)
  );

  // Effective level of the addressed slot, clamped to the bottom level
  always_comb begin
    if ((LvlW + 1)'(lvl_rdata) < (LvlW + 1)'(NUM_LEVELS)) begin
      l_eff = LIW'(lvl_rdata);
    end else begin
      l_eff = LIW'(NUM_LEVELS - 1);
    end
    if (((LIW + 1)'(l_eff) + (LIW + 1)'(1)) < (LIW + 1)'(NUM_LEVELS)) begin
      nl_eff = l_eff + LIW'(1);
    end else begin
      nl_eff = l_eff;
    end
  end

  // Highest nonempty queue, for pick
  always_comb begin
    found     = 1'b0;
    found_lvl = '0;
    for (int i = NUM_LEVELS - 1; i >= 0; i--) begin
      if (cnt_q[i] != '0) begin
        found     = 1'b1;
        found_lvl = LIW'(i);
      end
    end
  end

  // Any queue above the slot's final level nonempty, for tick
  always_comb begin
    fl      = fire_q ? nl_q : l_q;
    hi_busy = 1'b0;
    for (int i = 0; i < NUM_LEVELS; i++) begin
      if ((LIW'(i) < fl) && (cnt_q[i] != '0)) begin
        hi_busy = 1'b1;
      end
    end
  end

  assign s_axis_tready = (state_q == ST_IDLE);

  // Command sequencer
  always_comb begin
    state_d     = state_q;
    cmd_d       = cmd_q;
    sid_d       = sid_q;
    wt_d        = wt_q;
    rt_d        = rt_q;
    ok_d        = ok_q;
    l_d         = l_q;
    nl_d        = nl_q;
    tgt_d       = tgt_q;
    fire_d      = fire_q;
    idx_d       = idx_q;
    cnt_d       = cnt_q;
    queued_d    = queued_q;
    r_cv_d      = r_cv_q;
    r_cs_d      = r_cs_q;
    r_pre_d     = r_pre_q;
    r_st_d      = r_st_q;
    r_lv_d      = r_lv_q;
    out_valid_d = out_valid_q;
    out_data_d  = out_data_q;
    ent_we      = 1'b0;
    ent_waddr   = '0;
    ent_wdata   = '0;
    ent_re      = 1'b0;
    ent_raddr   = '0;
    lvl_we      = 1'b0;
    lvl_waddr   = sid_idx;
    lvl_wdata   = '0;
    lvl_re      = 1'b0;
    lvl_raddr   = SW'(s_axis_tdata[8:3]);

    // Drop the result once transferred
    if (out_valid_q && m_axis_tready) begin
      out_valid_d = 1'b0;
    end

    unique case (state_q)
      ST_IDLE: begin
        if (s_axis_tvalid) begin
          cmd_d   = s_axis_tdata[2:0];
          sid_d   = s_axis_tdata[8:3];
          wt_d    = s_axis_tdata[24:9];
          rt_d    = s_axis_tdata[40:25];
          ok_d    = (SW + 1)'(s_axis_tdata[8:3]) < (SW + 1)'(NUM_SLOTS)
                    && ((SW >= SlotIdW) || (s_axis_tdata[8:3] < SlotIdW'(NUM_SLOTS)));
          fire_d  = 1'b0;
          r_cv_d  = 1'b0;
          r_cs_d  = '0;
          r_pre_d = 1'b0;
          r_st_d  = StOk;
          r_lv_d  = '0;
          lvl_re  = 1'b1;
          state_d = ST_SLOT;
        end
      end
      ST_SLOT: begin
        l_d    = l_eff;
        nl_d   = nl_eff;
        idx_d  = '0;
        r_lv_d = ok_q ? lvl_rdata : '0;
        state_d = ST_OUT;
        if (cmd_q == CmdPick) begin
          if (found) begin
            r_cv_d    = 1'b1;
            ent_re    = 1'b1;
            ent_raddr = ent_addr(found_lvl, '0);
            state_d   = ST_PICK;
          end
        end else if (cmd_q > CmdPick) begin
          state_d = ST_OUT;
        end else if (!ok_q) begin
          r_st_d = StNotFound;
        end else if (cmd_q == CmdReady) begin
          if (!queued_q[sid_idx]) begin
            tgt_d   = l_eff;
            state_d = ST_PUSH;
          end
        end else if (cmd_q == CmdBlock) begin
          if (queued_q[sid_idx]) begin
            state_d = ST_SRD;
          end else begin
            r_st_d = StNotFound;
          end
        end else if (cmd_q == CmdAge) begin
          if (queued_q[sid_idx] && (l_eff != '0) && (wt_q >= age_limit_q)) begin
            state_d = ST_SRD;
          end
        end else begin
          // Tick: demote on an expired slice
          if ((TickW + 1)'(rt_q) >= ((TickW + 1)'(1) << l_eff)) begin
            fire_d    = 1'b1;
            r_pre_d   = 1'b1;
            r_lv_d    = LvlW'(nl_eff);
            lvl_we    = 1'b1;
            lvl_wdata = LvlW'(nl_eff);
            tgt_d     = nl_eff;
            if (cnt_q[l_eff] != '0) begin
              state_d = ST_RMRD;
            end else begin
              state_d = ST_PUSH;
            end
          end else begin
            state_d = ST_FIN;
          end
        end
      end
      ST_PICK: begin
        r_cs_d  = ent_rdata;
        state_d = ST_OUT;
      end
      ST_SRD: begin
        if (idx_q < cnt_q[l_q]) begin
          ent_re    = 1'b1;
          ent_raddr = ent_addr(l_q, idx_q);
          state_d   = ST_SCHK;
        end else begin
          r_st_d  = StNotFound;
          state_d = ST_OUT;
        end
      end
      ST_SCHK: begin
        if (ent_rdata == sid_q) begin
          if ((cmd_q == CmdAge) && (cnt_q[l_q - LIW'(1)] >= CW'(NUM_SLOTS))) begin
            r_st_d  = StFull;
            state_d = ST_OUT;
          end else begin
            queued_d[sid_idx] = 1'b0;
            state_d = ST_SHRD;
          end
        end else begin
          idx_d   = idx_q + CW'(1);
          state_d = ST_SRD;
        end
      end
      ST_RMRD: begin
        ent_re    = 1'b1;
        ent_raddr = ent_addr(l_q, '0);
        state_d   = ST_RMCLR;
      end
      ST_RMCLR: begin
        queued_d[SW'(ent_rdata)] = 1'b0;
        state_d = ST_SHRD;
      end
      ST_SHRD: begin
        // Move later entries forward one place
        if ((idx_q + CW'(1)) < cnt_q[l_q]) begin
          ent_re    = 1'b1;
          ent_raddr = ent_addr(l_q, idx_q + CW'(1));
          state_d   = ST_SHWR;
        end else begin
          cnt_d[l_q] = cnt_q[l_q] - CW'(1);
          if (cmd_q == CmdBlock) begin
            state_d = ST_OUT;
          end else if (cmd_q == CmdAge) begin
            tgt_d   = l_q - LIW'(1);
            state_d = ST_PUSH;
          end else begin
            state_d = ST_PUSH;
          end
        end
      end
      ST_SHWR: begin
        ent_we    = 1'b1;
        ent_waddr = ent_addr(l_q, idx_q);
        ent_wdata = ent_rdata;
        idx_d     = idx_q + CW'(1);
        state_d   = ST_SHRD;
      end
      ST_PUSH: begin
        if (cnt_q[tgt_q] >= CW'(NUM_SLOTS)) begin
          r_st_d = StFull;
        end else begin
          ent_we            = 1'b1;
          ent_waddr         = ent_addr(tgt_q, cnt_q[tgt_q]);
          ent_wdata         = sid_q;
          cnt_d[tgt_q]      = cnt_q[tgt_q] + CW'(1);
          queued_d[sid_idx] = 1'b1;
          lvl_we            = 1'b1;
          lvl_wdata         = LvlW'(tgt_q);
          r_lv_d            = LvlW'(tgt_q);
        end
        state_d = (cmd_q == CmdTick) ? ST_FIN : ST_OUT;
      end
      ST_FIN: begin
        if (hi_busy) begin
          r_pre_d = 1'b1;
        end
        state_d = ST_OUT;
      end
      ST_OUT: begin
        // Hand the result to the output register when it is free
        if (!out_valid_q || m_axis_tready) begin
          out_valid_d = 1'b1;
          out_data_d  = {3'b000, r_lv_q, r_st_q, r_pre_q, r_cs_q, r_cv_q};
          state_d     = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // Control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
      queued_q    <= '0;
      age_limit_q <= AgeLimitRst;
      for (int i = 0; i < NUM_LEVELS; i++) begin
        cnt_q[i] <= '0;
      end
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
      queued_q    <= queued_d;
      cnt_q       <= cnt_d;
      if (cfg_we_i) begin
        age_limit_q <= cfg_wdata_i;
      end
    end
  end

  // Command and result payload
  always_ff @(posedge clk_i) begin
    cmd_q      <= cmd_d;
    sid_q      <= sid_d;
    wt_q       <= wt_d;
    rt_q       <= rt_d;
    ok_q       <= ok_d;
    l_q        <= l_d;
    nl_q       <= nl_d;
    tgt_q      <= tgt_d;
    fire_q     <= fire_d;
    idx_q      <= idx_d;
    r_cv_q     <= r_cv_d;
    r_cs_q     <= r_cs_d;
    r_pre_q    <= r_pre_d;
    r_st_q     <= r_st_d;
    r_lv_q     <= r_lv_d;
    out_data_q <= out_data_d;
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;

`ifndef SYNTH
  // A shift write always returns to the next shift read
  a_shift_loop: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_SHWR) |=> (state_q == ST_SHRD))
    else $error("shift write not followed by shift read");

  // The level lookup only follows an accepted command
  a_slot_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_SLOT) |-> $past(s_axis_tvalid && s_axis_tready))
    else $error("level lookup without accepted command");

  // A new result is only loaded from the result state
  a_out_from_seq: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(m_axis_tvalid) |-> $past(state_q == ST_OUT))
    else $error("result raised outside result state");

  // Entry writes stay inside the queue memory
  a_ent_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ent_we |-> (ent_waddr < AW'(DEPTH - 1) || ent_waddr == AW'(DEPTH - 1)))
    else $error("entry write out of range");
`endif

endmodule
